// ===== rtl/event_leaky_integrator_core_defines.svh =====
// Assertion macros shared by the checker of the event leaky integrator.
// Stand-alone header; the checker takes it in before its module header.
`ifndef EVENT_LEAKY_INTEGRATOR_CORE_DEFINES_SVH
`define EVENT_LEAKY_INTEGRATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define ELI_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("event leaky integrator check failed");

// Next-cycle implication, sampled on the rising edge, off during reset
`define ELI_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("event leaky integrator check failed");

`endif

// ===== rtl/eli_pkg.sv =====
// Shared types, constants and the decay table of the event leaky integrator.
// No dependencies; eli_cfg, eli_update, the top level and the checker import this package.
package eli_pkg;

  // Sensor geometry and table size (table depth must be a power of two)
  localparam int FRAME_WIDTH       = 256;
  localparam int FRAME_HEIGHT      = 256;
  localparam int DECAY_TABLE_DEPTH = 256;

  localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PIX_AW      = $clog2(PIXEL_COUNT);
  localparam int IDX_W       = $clog2(DECAY_TABLE_DEPTH);

  // Field widths
  localparam int COORD_W    = 8;
  localparam int TS_W       = 32;
  localparam int BRIGHT_W   = 24;
  localparam int RATE_W     = 18;
  localparam int CONTRAST_W = 16;
  localparam int BETA_W     = 17;
  localparam int FRAC_W     = 16;

  // Datapath widths
  localparam int HALF_PROD_W = RATE_W + TS_W / 2;
  localparam int PROD_W      = RATE_W + TS_W;
  localparam int REM_W       = 31;
  localparam int SCALED_W    = BRIGHT_W + BETA_W + 1;
  localparam int ROUND_W     = SCALED_W - FRAC_W;
  localparam int SUM_W       = ROUND_W + 1;

  // rate * dt at which the exponent reaches 8 (rate in 1/256 s, dt in us)
  localparam longint EXP_LIMIT  = 64'd2048000000;
  localparam int     DIV_CONST  = 2048000000 / DECAY_TABLE_DEPTH;
  localparam int     ROUND_HALF = 1 << (FRAC_W - 1);

  // Table index by reciprocal multiplication: for any value below 2^REM_W,
  // (value * RECIP) >> RECIP_SHIFT equals value / DIV_CONST rounded down
  localparam int                 RECIP_SHIFT  = REM_W + $clog2(DIV_CONST);
  localparam int                 RECIP_W      = REM_W + 1;
  localparam int                 RECIP_PROD_W = REM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP        =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_CONST) - 64'd1) / 64'(DIV_CONST));

  localparam logic signed [BRIGHT_W-1:0] BRIGHT_MAX = 24'sh7FFFFF;
  localparam logic signed [BRIGHT_W-1:0] BRIGHT_MIN = -24'sh800000;

  // Configuration port
  localparam int REG_ADDR_W = 4;
  localparam int REG_SEL_W  = REG_ADDR_W - 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [RATE_W-1:0]     DECAY_RATE_RESET   = 18'd1280;
  localparam logic [CONTRAST_W-1:0] CONTRAST_POS_RESET = 16'd6554;
  localparam logic [CONTRAST_W-1:0] CONTRAST_NEG_RESET = 16'd6554;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_DECAY_RATE   = 2'd0,
    REG_CONTRAST_POS = 2'd1,
    REG_CONTRAST_NEG = 2'd2
  } eli_reg_t;

  typedef struct packed {
    logic [RATE_W-1:0]     decay_rate;
    logic [CONTRAST_W-1:0] contrast_positive;
    logic [CONTRAST_W-1:0] contrast_negative;
  } eli_cfg_t;

  // One request to both pixel stores; they share the address
  typedef struct packed {
    logic                       we;
    logic [PIX_AW-1:0]          addr;
    logic signed [BRIGHT_W-1:0] bright_wdata;
    logic [TS_W-1:0]            time_wdata;
  } eli_mem_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV,
    ST_LOOKUP,
    ST_SCALE,
    ST_FINISH
  } eli_state_t;

  // exp(-n) in Q32 for the integer part of the exponent
  function automatic logic [63:0] exp_int_q32(input logic [2:0] n);
    logic [63:0] r;
    case (n)
      3'd0:    r = 64'd4294967296;
      3'd1:    r = 64'd1580030169;
      3'd2:    r = 64'd581260615;
      3'd3:    r = 64'd213833830;
      3'd4:    r = 64'd78665072;
      3'd5:    r = 64'd28939262;
      3'd6:    r = 64'd10646159;
      default: r = 64'd3916504;
    endcase
    return r;
  endfunction

  // exp(-8k/DEPTH) in Q1.16: Taylor series on the fraction, times exp(-n)
  function automatic logic [BETA_W-1:0] decay_entry(input int k);
    logic [63:0] y;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] v;
    logic [2:0]  n;
    y    = (64'(k) << 35) / DECAY_TABLE_DEPTH;
    n    = y[34:32];
    f    = {32'd0, y[31:0]};
    term = 64'h1_0000_0000;
    pos  = term;
    neg  = 64'd0;
    for (int i = 1; i < 24; i++) begin
      term = ((term * f) >> 32) / 64'(i);
      if (i % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    v = (pos >= neg) ? pos - neg : 64'd0;
    v = (v * (exp_int_q32(n) >> 16)) >> 16;
    return BETA_W'((v + 64'd32768) >> 16);
  endfunction

  typedef logic [BETA_W-1:0] decay_table_t [DECAY_TABLE_DEPTH];

  function automatic decay_table_t build_decay_table();
    decay_table_t t;
    for (int k = 0; k < DECAY_TABLE_DEPTH; k++) begin
      t[k] = decay_entry(k);
    end
    return t;
  endfunction

  localparam decay_table_t DECAY_TABLE = build_decay_table();

endpackage

// ===== rtl/eli_ram.sv =====
// Generic single-port synchronous RAM with registered read (read-first).
// No dependencies; used for both per-pixel stores.
module eli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, register the read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/eli_cfg.sv =====
// APB-style configuration registers of the event leaky integrator.
// Depends on eli_pkg for widths, register codes and reset values.
module eli_cfg import eli_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output eli_cfg_t              cfg
);

  logic                 wr_en;
  logic [REG_SEL_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[REG_ADDR_W-1:2];

  // Take a write in the access phase; unknown addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_rate        <= DECAY_RATE_RESET;
      cfg.contrast_positive <= CONTRAST_POS_RESET;
      cfg.contrast_negative <= CONTRAST_NEG_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_DECAY_RATE:   cfg.decay_rate        <= pwdata[RATE_W-1:0];
        REG_CONTRAST_POS: cfg.contrast_positive <= pwdata[CONTRAST_W-1:0];
        REG_CONTRAST_NEG: cfg.contrast_negative <= pwdata[CONTRAST_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_sel)
      REG_DECAY_RATE:   prdata = CFG_DATA_W'(cfg.decay_rate);
      REG_CONTRAST_POS: prdata = CFG_DATA_W'(cfg.contrast_positive);
      REG_CONTRAST_NEG: prdata = CFG_DATA_W'(cfg.contrast_negative);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/eli_update.sv =====
// Per-event sequencer: clears the stores, reads a pixel, decays and steps it,
// writes it back and registers the result. Depends on eli_pkg.
module eli_update import eli_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  eli_cfg_t                   cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [COORD_W-1:0]         pixel_x,
  input  logic [COORD_W-1:0]         pixel_y,
  input  logic [TS_W-1:0]            timestamp,
  input  logic                       polarity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COORD_W-1:0]         out_x,
  output logic [COORD_W-1:0]         out_y,
  output logic signed [BRIGHT_W-1:0] brightness,
  output eli_mem_req_t               mem_req,
  input  logic signed [BRIGHT_W-1:0] bright_rdata,
  input  logic [TS_W-1:0]            time_rdata
);

  eli_state_t state, state_next;

  logic                       accept;
  logic                       in_outside;
  logic [PIX_AW-1:0]          in_addr;
  logic [PIX_AW-1:0]          clear_addr;
  logic [PIX_AW-1:0]          ev_addr;
  logic [COORD_W-1:0]         ev_x;
  logic [COORD_W-1:0]         ev_y;
  logic [TS_W-1:0]            ev_ts;
  logic                       ev_pol;
  logic                       ev_outside;
  logic signed [BRIGHT_W-1:0] bright_q;
  logic [TS_W-1:0]            dt;
  logic [HALF_PROD_W-1:0]     prod_lo;
  logic [HALF_PROD_W-1:0]     prod_hi;
  logic [PROD_W-1:0]          prod_sum;
  logic                       in_range;
  logic [REM_W-1:0]           rem;
  logic [RECIP_PROD_W-1:0]    recip_prod;
  logic [IDX_W-1:0]           quot;
  logic [BETA_W-1:0]          beta;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [ROUND_W-1:0]  rounded;
  logic signed [SUM_W-1:0]    sum_val;
  logic signed [BRIGHT_W-1:0] result_sat;
  logic                       finish_go;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Locate the event in the stores
  assign in_outside = (32'(pixel_x) >= FRAME_WIDTH) || (32'(pixel_y) >= FRAME_HEIGHT);
  assign in_addr    = PIX_AW'(32'(pixel_y) * 32'(FRAME_WIDTH) + 32'(pixel_x));

  // Join the two partial products of rate * dt
  assign prod_sum  = PROD_W'(prod_lo) + (PROD_W'(prod_hi) << (TS_W / 2));

  // Scale by the reciprocal of the index step; the quotient sits above RECIP_SHIFT
  assign recip_prod = RECIP_PROD_W'(rem) * RECIP_PROD_W'(RECIP);

  // Round the decayed value half up, then add or subtract the step
  assign rounded = ROUND_W'((scaled + SCALED_W'(ROUND_HALF)) >>> FRAC_W);
  assign sum_val = ev_pol ?
                   SUM_W'(rounded) + $signed(SUM_W'(cfg.contrast_positive)) :
                   SUM_W'(rounded) - $signed(SUM_W'(cfg.contrast_negative));

  // Clamp to signed Q7.16
  always_comb begin
    if (sum_val > SUM_W'(BRIGHT_MAX)) begin
      result_sat = BRIGHT_MAX;
    end else if (sum_val < SUM_W'(BRIGHT_MIN)) begin
      result_sat = BRIGHT_MIN;
    end else begin
      result_sat = BRIGHT_W'(sum_val);
    end
  end

  // Hold the finishing step while the output register is still occupied
  assign finish_go = !(out_valid && !out_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == PIX_AW'(PIXEL_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = in_outside ? ST_FINISH : ST_READ;
      end
      ST_READ:   state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = ST_DIV;
      ST_DIV:    state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (finish_go) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Store access: sweep after reset, read on accept, write back at the end
  always_comb begin
    mem_req.we           = 1'b0;
    mem_req.addr         = ev_addr;
    mem_req.bright_wdata = result_sat;
    mem_req.time_wdata   = ev_ts;
    case (state)
      ST_CLEAR: begin
        mem_req.we           = 1'b1;
        mem_req.addr         = clear_addr;
        mem_req.bright_wdata = '0;
        mem_req.time_wdata   = '0;
      end
      ST_IDLE:   mem_req.addr = in_addr;
      ST_FINISH: mem_req.we   = finish_go && !ev_outside;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (state == ST_FINISH && finish_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, advanced one step per state
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ev_x       <= pixel_x;
          ev_y       <= pixel_y;
          ev_ts      <= timestamp;
          ev_pol     <= polarity;
          ev_outside <= in_outside;
          ev_addr    <= in_addr;
        end
      end
      ST_READ: begin
        bright_q <= bright_rdata;
        dt       <= ev_ts - time_rdata;
      end
      ST_MUL_LO: begin
        prod_lo <= HALF_PROD_W'(cfg.decay_rate) * HALF_PROD_W'(dt[TS_W/2-1:0]);
      end
      ST_MUL_HI: begin
        prod_hi <= HALF_PROD_W'(cfg.decay_rate) * HALF_PROD_W'(dt[TS_W-1:TS_W/2]);
      end
      ST_SUM: begin
        in_range <= (prod_sum < PROD_W'(EXP_LIMIT));
        rem      <= prod_sum[REM_W-1:0];
      end
      ST_DIV: begin
        quot <= recip_prod[RECIP_SHIFT +: IDX_W];
      end
      ST_LOOKUP: begin
        beta <= in_range ? DECAY_TABLE[quot] : '0;
      end
      ST_SCALE: begin
        scaled <= bright_q * $signed({1'b0, beta});
      end
      ST_FINISH: begin
        if (finish_go) begin
          out_x      <= ev_x;
          out_y      <= ev_y;
          brightness <= ev_outside ? '0 : result_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/event_leaky_integrator_core.sv =====
// Event leaky integrator. One event is taken at a time: an in-frame event
// occupies the block from its transfer until the next event can be taken,
// a span set by the single-port pixel stores (read, then write back) and
// the decay arithmetic done one step a cycle (two partial products of rate
// times elapsed time, their sum, the table index by reciprocal multiply, the
// lookup and the scaling); an out-of-frame event skips to the last step and
// leaves the stores untouched. The result sits in an output register, so the
// next event is taken while it waits; that next event then holds in its last
// step until the register is freed. After reset the block sweeps both pixel
// stores to zero, one pixel a cycle, all FRAME_WIDTH * FRAME_HEIGHT (65536)
// pixels, before it takes an event; configuration writes are taken throughout.
// Depends on eli_pkg, eli_cfg, eli_update and eli_ram.
module event_leaky_integrator_core import eli_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [REG_ADDR_W-1:0]      paddr,
  input  logic [CFG_DATA_W-1:0]      pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [COORD_W-1:0]         pixel_x,
  input  logic [COORD_W-1:0]         pixel_y,
  input  logic [TS_W-1:0]            timestamp,
  input  logic                       polarity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [COORD_W-1:0]         out_x,
  output logic [COORD_W-1:0]         out_y,
  output logic signed [BRIGHT_W-1:0] brightness
);

  eli_cfg_t                   cfg;
  eli_mem_req_t               mem_req;
  logic signed [BRIGHT_W-1:0] bright_rdata;
  logic [TS_W-1:0]            time_rdata;

  // Configuration registers
  eli_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Event sequencer and datapath
  eli_update u_update (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .timestamp    (timestamp),
    .polarity     (polarity),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .brightness   (brightness),
    .mem_req      (mem_req),
    .bright_rdata (bright_rdata),
    .time_rdata   (time_rdata)
  );

  // Per-pixel brightness store
  eli_ram #(
    .WIDTH (BRIGHT_W),
    .DEPTH (PIXEL_COUNT)
  ) u_bright_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.bright_wdata),
    .rdata (bright_rdata)
  );

  // Per-pixel last event time store
  eli_ram #(
    .WIDTH (TS_W),
    .DEPTH (PIXEL_COUNT)
  ) u_time_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.time_wdata),
    .rdata (time_rdata)
  );

endmodule

// ===== rtl/eli_checker.sv =====
// Port-level checks of the event leaky integrator, bound to the top level.
// Depends on eli_pkg and the shared assertion macro header.
`include "event_leaky_integrator_core_defines.svh"

module eli_checker import eli_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [COORD_W-1:0]         out_x,
  input logic [COORD_W-1:0]         out_y,
  input logic signed [BRIGHT_W-1:0] brightness
);

  logic [1:0] pending;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Count events taken whose result has not yet been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

  // A result only ever belongs to an event already taken
  `ELI_ASSERT_IMPL(a_no_spurious_result, clk, rst, out_valid, pending != 2'd0)

  // At most one event in work plus one result waiting
  `ELI_ASSERT_IMPL(a_bounded_backlog, clk, rst, 1'b1, pending != 2'd3)

  // Events are worked one at a time
  `ELI_ASSERT_NEXT(a_one_event_at_a_time, clk, rst, in_xfer, !in_ready)

  // A stalled result holds its payload
  `ELI_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(brightness))

endmodule

bind event_leaky_integrator_core eli_checker u_checker (.*);
